// File: rtl/efr_pkg.sv
package efr_pkg;

  localparam logic [7:0] ESC_MARK = 8'hA5;
  localparam logic [7:0] SOP_MARK = 8'hAA;
  localparam logic [7:0] EOP_MARK = 8'hBB;

  localparam logic [15:0] LEN_RESET = 16'd256;

  localparam logic [1:0] FS_NONE = 2'd0;
  localparam logic [1:0] FS_GOOD = 2'd1;
  localparam logic [1:0] FS_BAD  = 2'd2;

  typedef enum logic [3:0] {
    PH_HUNT_ESC = 4'b0001,
    PH_HUNT_SOP = 4'b0010,
    PH_DATA     = 4'b0100,
    PH_ESCAPED  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        store_valid;
    logic [15:0] store_index;
    logic [7:0]  store_data;
    logic [1:0]  frame_status;
  } result_t;

  // CRC-16/ARC nibble table (reflected polynomial 0xA001)
  function automatic logic [15:0] crc_nib_tab(input logic [3:0] n);
    logic [15:0] t;
    case (n)
      4'h0: t = 16'h0000;
      4'h1: t = 16'hCC01;
      4'h2: t = 16'hD801;
      4'h3: t = 16'h1400;
      4'h4: t = 16'hF001;
      4'h5: t = 16'h3C00;
      4'h6: t = 16'h2800;
      4'h7: t = 16'hE401;
      4'h8: t = 16'hA001;
      4'h9: t = 16'h6C00;
      4'hA: t = 16'h7800;
      4'hB: t = 16'hB401;
      4'hC: t = 16'h5000;
      4'hD: t = 16'h9C01;
      4'hE: t = 16'h8801;
      4'hF: t = 16'h4400;
      default: t = 16'h0000;
    endcase
    return t;
  endfunction

  function automatic logic [15:0] crc_nib_step(input logic [15:0] c, input logic [3:0] n);
    return {4'h0, c[15:4]} ^ crc_nib_tab(c[3:0]) ^ crc_nib_tab(n);
  endfunction

endpackage

// File: rtl/efr_if.sv
interface efr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface efr_res_if;
  logic        valid;
  logic        ready;
  logic        store_valid;
  logic [15:0] store_index;
  logic [7:0]  store_data;
  logic [1:0]  frame_status;

  modport source (output valid, output store_valid, output store_index,
                  output store_data, output frame_status, input ready);
  modport sink (input valid, input store_valid, input store_index,
                input store_data, input frame_status, output ready);
endinterface

interface efr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_buffer_length;

  modport source (output valid, output frame_buffer_length, input ready);
  modport sink (input valid, input frame_buffer_length, output ready);
endinterface

// File: rtl/efr_crc.sv
// CRC-16/ARC update by one byte, low nibble first.
module efr_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  logic [15:0] crc_lo;

  assign crc_lo  = efr_pkg::crc_nib_step(crc_in, data[3:0]);
  assign crc_out = efr_pkg::crc_nib_step(crc_lo, data[7:4]);

endmodule

// File: rtl/escaped_frame_rx_deframer_crc16.sv
// Byte-stuffed frame receiver with CRC-16/ARC check. Each request on rx
// carries one received byte and yields exactly one request on result. The
// receiver hunts for the start marker A5 AA, which clears the write index
// and the CRC; inside a frame A5 escapes: A5 A5 is a literal A5 data byte,
// A5 BB ends the frame and reports good (CRC residue zero) or bad. Data
// bytes, the two trailing CRC bytes included, come out with store_valid set
// and a buffer index below frame_buffer_length (reset 256) unless that is
// zero. The user must write frame_buffer_length over cfg only while the
// block is idle; the block itself does not enforce this. Throughput is one
// byte per clock while result is taken: the byte sits in an input register,
// one pass of decode logic and a two-nibble CRC update produces the result
// register, and rx stalls only when it is full and not being taken.
module escaped_frame_rx_deframer_crc16 (
  input logic       clk,
  input logic       rst,
  efr_rx_if.sink    rx,
  efr_res_if.source result,
  efr_cfg_if.sink   cfg
);

  // configuration
  logic [15:0] frame_buffer_length;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // receiver state
  efr_pkg::phase_t rx_phase, rx_phase_next;
  logic [15:0]     write_index, write_index_next;
  logic [15:0]     crc_value, crc_value_next;

  // result register
  logic             res_valid;
  efr_pkg::result_t res;
  efr_pkg::result_t res_next;

  logic        advance;
  logic [15:0] idx_eff;
  logic        take;
  logic        store;
  logic [15:0] crc_upd;

  // Move the held byte on when the result register is free or being drained.
  assign advance  = s1_valid && (!res_valid || result.ready);
  assign rx.ready = !s1_valid || advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_buffer_length <= efr_pkg::LEN_RESET;
    end else if (cfg.valid) begin
      frame_buffer_length <= cfg.frame_buffer_length;
    end
  end

  // Input stage: hold the byte until the decode pass can commit it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  efr_crc u_crc (
    .crc_in  (crc_value),
    .data    (s1_byte),
    .crc_out (crc_upd)
  );

  // Wrap the index before the byte is looked at.
  assign idx_eff = (write_index >= frame_buffer_length) ? 16'd0 : write_index;

  always_comb begin
    rx_phase_next    = rx_phase;
    write_index_next = idx_eff;
    crc_value_next   = crc_value;
    take             = 1'b0;
    res_next         = '0;

    case (rx_phase)
      efr_pkg::PH_HUNT_ESC: begin
        if (s1_byte == efr_pkg::ESC_MARK) begin
          rx_phase_next = efr_pkg::PH_HUNT_SOP;
        end
      end
      efr_pkg::PH_HUNT_SOP: begin
        // Start marker: restart the index and the CRC; anything else drops back.
        if (s1_byte == efr_pkg::SOP_MARK) begin
          rx_phase_next    = efr_pkg::PH_DATA;
          write_index_next = 16'd0;
          crc_value_next   = 16'd0;
        end else begin
          rx_phase_next = efr_pkg::PH_HUNT_ESC;
        end
      end
      efr_pkg::PH_DATA: begin
        if (s1_byte == efr_pkg::ESC_MARK) begin
          rx_phase_next = efr_pkg::PH_ESCAPED;
        end else begin
          take = 1'b1;
        end
      end
      efr_pkg::PH_ESCAPED: begin
        // Escaped escape is literal data; end marker closes the frame;
        // any other byte is dropped and the escape stays pending.
        if (s1_byte == efr_pkg::ESC_MARK) begin
          rx_phase_next = efr_pkg::PH_DATA;
          take          = 1'b1;
        end else if (s1_byte == efr_pkg::EOP_MARK) begin
          rx_phase_next         = efr_pkg::PH_HUNT_ESC;
          res_next.frame_status = (crc_value == 16'd0) ? efr_pkg::FS_GOOD
                                                       : efr_pkg::FS_BAD;
        end
      end
      default: begin
        rx_phase_next = efr_pkg::PH_HUNT_ESC;
      end
    endcase

    // A zero-length buffer stores nothing, but the CRC still sees the byte.
    store = take && (idx_eff < frame_buffer_length);
    if (take) begin
      crc_value_next = crc_upd;
    end
    if (store) begin
      write_index_next     = idx_eff + 16'd1;
      res_next.store_valid = 1'b1;
      res_next.store_index = idx_eff;
      res_next.store_data  = s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase    <= efr_pkg::PH_HUNT_ESC;
      write_index <= 16'd0;
      crc_value   <= 16'd0;
    end else if (advance) begin
      rx_phase    <= rx_phase_next;
      write_index <= write_index_next;
      crc_value   <= crc_value_next;
    end
  end

  // Result stage: hold until taken, refill in the same cycle it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.store_valid  = res.store_valid;
  assign result.store_index  = res.store_index;
  assign result.store_data   = res.store_data;
  assign result.frame_status = res.frame_status;

endmodule

// File: rtl/efr_checker.sv
module efr_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        store_valid,
  input logic [15:0] store_index,
  input logic [7:0]  store_data,
  input logic [1:0]  frame_status,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_length
);

  logic [15:0] len_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_shadow <= efr_pkg::LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      len_shadow <= cfg_length;
    end
  end

  // A stalled result holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(store_index) &&
      $stable(store_data) && $stable(frame_status) && $stable(store_valid))
    else $error("result changed while stalled");

  // A stored byte always lands inside the configured buffer.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && store_valid |-> store_index < len_shadow)
    else $error("store index beyond buffer length");

  // A byte is either data or a frame end, never both.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid && store_valid |-> frame_status == efr_pkg::FS_NONE)
    else $error("data byte with frame status");

  // Non-data results carry zero index and data.
  a_zero_fill: assert property (@(posedge clk) disable iff (rst)
    res_valid && !store_valid |-> store_index == 16'd0 && store_data == 8'd0)
    else $error("non-data result carries payload");

  // Nothing shows on the result side in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind escaped_frame_rx_deframer_crc16 efr_checker u_efr_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .store_valid  (result.store_valid),
  .store_index  (result.store_index),
  .store_data   (result.store_data),
  .frame_status (result.frame_status),
  .cfg_valid    (cfg.valid),
  .cfg_ready    (cfg.ready),
  .cfg_length   (cfg.frame_buffer_length)
);

// File: dv/efr_deframe_checker.sv
module efr_deframe_checker
  import efr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  efr_rx_if           rx,
  efr_res_if          res,
  efr_cfg_if          cfg,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  result_t     pending_results[$];
  phase_t      rx_state;
  logic [15:0] buf_len;
  logic [15:0] wr_slot;
  logic [15:0] frame_crc;

  // Bitwise CRC-16/ARC, LSB first.
  function automatic logic [15:0] arc_crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
    end
    return x;
  endfunction

  // Store one unescaped data byte; the CRC advances even when the buffer is full.
  function automatic result_t store_data_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    if (wr_slot < buf_len) begin
      r.store_valid = 1'b1;
      r.store_index = wr_slot;
      r.store_data  = b;
      wr_slot       = wr_slot + 16'd1;
    end
    frame_crc = arc_crc_update(frame_crc, b);
    return r;
  endfunction

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    if (wr_slot >= buf_len) wr_slot = '0;
    case (rx_state)
      PH_HUNT_ESC: begin
        if (b == ESC_MARK) rx_state = PH_HUNT_SOP;
      end
      PH_HUNT_SOP: begin
        if (b == SOP_MARK) begin
          rx_state  = PH_DATA;
          wr_slot   = '0;
          frame_crc = '0;
        end else begin
          rx_state = PH_HUNT_ESC;
        end
      end
      PH_DATA: begin
        if (b == ESC_MARK) rx_state = PH_ESCAPED;
        else r = store_data_byte(b);
      end
      default: begin
        if (b == ESC_MARK) begin
          rx_state = PH_DATA;
          r = store_data_byte(ESC_MARK);
        end else if (b == EOP_MARK) begin
          rx_state = PH_HUNT_ESC;
          r.frame_status = (frame_crc == 16'h0000) ? FS_GOOD : FS_BAD;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t seen;
    if (rst) begin
      pending_results.delete();
      rx_state   = PH_HUNT_ESC;
      buf_len    = LEN_RESET;
      wr_slot    = '0;
      frame_crc  = '0;
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) buf_len = cfg.frame_buffer_length;
      if (rx.valid && rx.ready) pending_results.push_back(deframe_byte(rx.rx_byte));
      if (res.valid && res.ready) begin
        seen.store_valid  = res.store_valid;
        seen.store_index  = res.store_index;
        seen.store_data   = res.store_data;
        seen.frame_status = res.frame_status;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: valid=%0b idx=%0d data=%02h status=%0d",
                     seen.store_valid, seen.store_index, seen.store_data,
                     seen.frame_status);
        end else begin
          want = pending_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp valid=%0b idx=%0d data=%02h status=%0d, %s",
                       want.store_valid, want.store_index, want.store_data,
                       want.frame_status,
                       $sformatf("got valid=%0b idx=%0d data=%02h status=%0d",
                                 seen.store_valid, seen.store_index, seen.store_data,
                                 seen.frame_status));
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// File: dv/escaped_frame_rx_deframer_crc16_tb.sv
module escaped_frame_rx_deframer_crc16_tb;
  import efr_pkg::*;

  // Stall length for the long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 300;
  // Bytes per random phase.
  localparam int PHASE_BYTES = 340;

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned bytes_sent;
  bit          idle_on;
  bit          hold_req;

  efr_rx_if  rx_ch ();
  efr_res_if res_ch ();
  efr_cfg_if cfg_ch ();

  escaped_frame_rx_deframer_crc16 u_top (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // The checker predicts every result from the accepted requests and counts failures.
  efr_deframe_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result side: take results with random back-pressure; on a hold request
  // drop ready for a long stretch so the block fills up and stalls rx.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= !(idle_on && $urandom_range(99) < 20);
      end
    end
  end

  // Offer one byte and hold it until accepted. Random gaps go in front of
  // the request; valid stays high between back-to-back requests.
  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 20) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  // Send one data byte with stuffing. An escaped data marker sometimes
  // carries an unknown escape code in between, which must leave the escape pending.
  task automatic send_stuffed(input logic [7:0] b);
    logic [7:0] junk;
    if (b == ESC_MARK) begin
      send_byte(ESC_MARK);
      if ($urandom_range(3) == 0) begin
        junk = 8'($urandom);
        if (junk == ESC_MARK || junk == EOP_MARK) junk = junk ^ 8'h01;
        send_byte(junk);
      end
      send_byte(ESC_MARK);
    end else begin
      send_byte(b);
    end
  endtask

  // Well-formed frame: start marker, random payload, CRC low byte then high
  // byte (zero residue when good), end marker. A bad frame flips CRC bits.
  task automatic send_frame(input int n, input bit good);
    logic [15:0] c;
    logic [7:0]  b;
    c = '0;
    send_byte(ESC_MARK);
    send_byte(SOP_MARK);
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(7) == 0) ? ESC_MARK : 8'($urandom);
      c = crc_nib_step(crc_nib_step(c, b[3:0]), b[7:4]);
      send_stuffed(b);
    end
    if (!good) c = c ^ 16'($urandom_range(1, 16'hFFFF));
    send_stuffed(c[7:0]);
    send_stuffed(c[15:8]);
    send_byte(ESC_MARK);
    send_byte(EOP_MARK);
  endtask

  // Hold the sender until every expected result is back, then let the
  // pipeline settle. Sample the count at the falling edge, away from updates.
  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write the buffer length only while the block is idle.
  task automatic set_length(input logic [15:0] len);
    drain_results();
    cfg_ch.valid               <= 1'b1;
    cfg_ch.frame_buffer_length <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // One random chunk of traffic: mostly well-formed frames, the rest
  // line noise and broken sequences.
  task automatic random_burst();
    int pick;
    pick = $urandom_range(99);
    if (pick < 72) begin
      send_frame(($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(12),
                 $urandom_range(9) != 0);
    end else if (pick < 82) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else if (pick < 88) begin
      // bad start: escape followed by the end code or a random byte
      send_byte(ESC_MARK);
      send_byte(($urandom_range(1) == 0) ? EOP_MARK : 8'($urandom));
    end else if (pick < 94) begin
      // truncated frame: start and a few bytes, no end marker
      send_byte(ESC_MARK);
      send_byte(SOP_MARK);
      repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
    end else begin
      // stray escape pairs and end markers
      send_byte(ESC_MARK);
      send_byte(($urandom_range(1) == 0) ? ESC_MARK : EOP_MARK);
    end
  endtask

  initial begin : stimulus
    logic [15:0] phase_len [6];
    int          stop_at;
    phase_len = '{16'd256, 16'd0, 16'd1, 16'd5, 16'hFFFF, 16'd0};
    phase_len[5] = 16'($urandom_range(2, 40));
    idle_on    = 1'b0;
    hold_req   = 1'b0;
    bytes_sent = 0;
    rst                        <= 1'b1;
    rx_ch.valid                <= 1'b0;
    rx_ch.rx_byte              <= 8'h00;
    cfg_ch.valid               <= 1'b0;
    cfg_ch.frame_buffer_length <= 16'h0000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset length of 256 slots.
    send_byte(8'h00);              // ignored while hunting
    send_byte(8'hFF);
    send_byte(ESC_MARK);           // bad start
    send_byte(8'h55);
    send_byte(ESC_MARK);           // frame start
    send_byte(SOP_MARK);
    send_byte(8'h00);              // plain data, marker codes included
    send_byte(8'hFF);
    send_byte(SOP_MARK);
    send_byte(EOP_MARK);
    send_byte(ESC_MARK);           // literal escape byte
    send_byte(ESC_MARK);
    send_byte(ESC_MARK);           // unknown escape, stays pending
    send_byte(8'h3C);
    send_byte(SOP_MARK);
    send_byte(ESC_MARK);           // pending escape resolves to literal
    send_byte(ESC_MARK);           // end of frame, bad CRC
    send_byte(EOP_MARK);
    send_frame(3, 1'b1);           // good CRC
    send_frame(0, 1'b1);           // CRC bytes only

    // Zero-length buffer: nothing stored, CRC still runs.
    set_length(16'd0);
    send_frame(2, 1'b1);
    // Short buffer: index wraps mid-frame.
    set_length(16'd3);
    send_frame(7, 1'b1);
    set_length(16'hFFFF);
    send_frame(4, 1'b0);

    // Random phases across several lengths. Phase 2 runs with no idling on
    // either side; phase 3 opens with a long receiver hold-off.
    for (int p = 0; p < 6; p++) begin
      set_length(phase_len[p]);
      idle_on = (p != 2);
      if (p == 3) hold_req = 1'b1;
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) random_burst();
    end

    drain_results();
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #10000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
